@@ hw/rtl/stack_machine_integer_alu_macros.svh @@
// assertion macros for the integer alu checker
`ifndef STACK_MACHINE_INTEGER_ALU_MACROS_SVH
`define STACK_MACHINE_INTEGER_ALU_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define SMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/smalu_pkg.sv @@
// package: operation codes, payload types and constants for the integer alu
package smalu_pkg;
  typedef enum logic [4:0] {
    OP_IADD = 5'd0, OP_LADD = 5'd1, OP_ISUB = 5'd2, OP_LSUB = 5'd3,
    OP_IMUL = 5'd4, OP_LMUL = 5'd5, OP_IDIV = 5'd6, OP_LDIV = 5'd7,
    OP_IREM = 5'd8, OP_LREM = 5'd9, OP_INEG = 5'd10, OP_LNEG = 5'd11,
    OP_ISHL = 5'd12, OP_ISHR = 5'd13, OP_IUSHR = 5'd14, OP_LSHL = 5'd15,
    OP_LSHR = 5'd16, OP_LUSHR = 5'd17, OP_IAND = 5'd18, OP_LAND = 5'd19,
    OP_IOR = 5'd20, OP_LOR = 5'd21, OP_IXOR = 5'd22, OP_LXOR = 5'd23,
    OP_LCMP = 5'd24
  } op_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

  // back-end sequencing
  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} st_t;

  localparam int QDepth = 4;
  localparam int QAw = 2;
  localparam int DivSteps = 64;
  localparam int DivCw = 7;

  // decoded item travelling from front to back
  typedef struct packed {
    cls_t        cls;
    logic        is_long;
    logic        is_rem;
    logic        div_zero;
    logic        div_ovf;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] simple_res;
  } dec_t;

  typedef struct packed {
    logic [63:0] result;
    logic        divide_by_zero;
  } res_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction
endpackage

@@ hw/rtl/smalu_if.sv @@
// valid/ready channel interfaces for input and result transactions
interface smalu_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic signed [63:0] first_value;
  logic signed [63:0] second_value;
  modport source (output valid, op, first_value, second_value, input ready);
  modport sink (input valid, op, first_value, second_value, output ready);
endinterface

interface smalu_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic signed [63:0] result;
  logic        divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface

@@ hw/rtl/smalu_front.sv @@
// front end: classifies operations and computes the simple results combinationally
module smalu_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_op,
  input  logic [63:0]          in_a,
  input  logic [63:0]          in_b,
  output logic                 q_push,
  output smalu_pkg::dec_t      q_data,
  input  logic                 q_full
);
  import smalu_pkg::*;

  logic [31:0] a32, b32;
  logic [4:0]  si;
  logic [5:0]  sl;
  logic [63:0] sres;
  logic        il;
  logic [63:0] da, db;

  assign a32 = in_a[31:0];
  assign b32 = in_b[31:0];
  assign si  = in_b[4:0];
  assign sl  = in_b[5:0];
  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    sres = 64'd0;
    case (in_op)
      OP_IADD:  sres = sext32(a32 + b32);
      OP_LADD:  sres = in_a + in_b;
      OP_ISUB:  sres = sext32(a32 - b32);
      OP_LSUB:  sres = in_a - in_b;
      OP_INEG:  sres = sext32(32'd0 - a32);
      OP_LNEG:  sres = 64'd0 - in_a;
      OP_ISHL:  sres = sext32(a32 << si);
      OP_ISHR:  sres = sext32($unsigned($signed(a32) >>> si));
      OP_IUSHR: sres = sext32(a32 >> si);
      OP_LSHL:  sres = in_a << sl;
      OP_LSHR:  sres = $unsigned($signed(in_a) >>> sl);
      OP_LUSHR: sres = in_a >> sl;
      OP_IAND:  sres = sext32(a32 & b32);
      OP_LAND:  sres = in_a & in_b;
      OP_IOR:   sres = sext32(a32 | b32);
      OP_LOR:   sres = in_a | in_b;
      OP_IXOR:  sres = sext32(a32 ^ b32);
      OP_LXOR:  sres = in_a ^ in_b;
      OP_LCMP: begin
        if ($signed(in_a) > $signed(in_b)) sres = 64'd1;
        else if (in_a == in_b) sres = 64'd0;
        else sres = {64{1'b1}};
      end
      default:  sres = 64'd0;
    endcase
  end

  // operands for mul/div: int ops are sign-extended to 64 bits
  always_comb begin
    il = (in_op == OP_LMUL) || (in_op == OP_LDIV) || (in_op == OP_LREM);
    da = il ? in_a : sext32(a32);
    db = il ? in_b : sext32(b32);
    q_data = '0;
    q_data.is_long = il;
    q_data.is_rem = (in_op == OP_IREM) || (in_op == OP_LREM);
    q_data.simple_res = sres;
    q_data.a = da;
    q_data.b = db;
    q_data.div_zero = (db == 64'd0);
    q_data.div_ovf = il ? (in_a == 64'h8000_0000_0000_0000 && in_b == '1)
                        : (a32 == 32'h8000_0000 && b32 == '1);
    q_data.neg_q = da[63] ^ db[63];
    q_data.neg_r = da[63];
    case (in_op)
      OP_IMUL, OP_LMUL: q_data.cls = CLS_MUL;
      OP_IDIV, OP_LDIV, OP_IREM, OP_LREM: q_data.cls = CLS_DIV;
      default: q_data.cls = CLS_SIMPLE;
    endcase
  end
endmodule

@@ hw/rtl/smalu_queue.sv @@
// small fifo between front and back ends
module smalu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  smalu_pkg::dec_t push_data,
  output logic            full,
  input  logic            pop,
  output smalu_pkg::dec_t pop_data,
  output logic            not_empty
);
  import smalu_pkg::*;

  dec_t mem_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == (QAw+1)'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];
  assign cnt_nxt = cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

@@ hw/rtl/smalu_back.sv @@
// back end: multiplier with registered partial products, iterative divider and output register
module smalu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  smalu_pkg::dec_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     out_result,
  output logic            out_dbz
);
  import smalu_pkg::*;

  st_t st_r, st_nxt;

  dec_t        cur_r;
  logic [63:0] pp_ll_r, pp_lh_r, pp_hl_r;
  logic [63:0] q_r, rem_r, dv_r;
  logic [DivCw-1:0] cnt_r;
  logic        ov_r, ov_nxt;
  logic [63:0] res_r;
  logic        dbz_r;
  logic        fin, can_load;
  logic [64:0] trial;
  logic [63:0] rsh, mres, dres, qv, rv, mag_a, mag_b;

  assign out_valid = ov_r;
  assign out_result = res_r;
  assign out_dbz = dbz_r;
  assign can_load = !ov_r || out_ready;
  assign mag_a = q_data.a[63] ? (64'd0 - q_data.a) : q_data.a;
  assign mag_b = q_data.b[63] ? (64'd0 - q_data.b) : q_data.b;
  assign rsh = {rem_r[62:0], q_r[63]};
  assign trial = {1'b0, rsh} - {1'b0, dv_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid && q_data.cls == CLS_MUL) st_nxt = ST_MUL;
        else if (q_valid && q_data.cls == CLS_DIV && !q_data.div_zero && !q_data.div_ovf)
          st_nxt = ST_DIV;
        else if (q_valid && !can_load) st_nxt = ST_IDLE;
      ST_MUL: st_nxt = ST_DONE;
      ST_DIV: if (cnt_r == DivCw'(DivSteps - 1)) st_nxt = ST_DONE;
      ST_DONE: if (can_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // fast path retires straight from the queue head into the output register
  always_comb begin
    q_pop = 1'b0;
    fin = 1'b0;
    case (st_r)
      ST_IDLE: q_pop = q_valid && (q_data.cls != CLS_SIMPLE
                 && !(q_data.cls == CLS_DIV && (q_data.div_zero || q_data.div_ovf))
                 || can_load);
      ST_DONE: fin = can_load;
      default: begin
        q_pop = 1'b0;
        fin = 1'b0;
      end
    endcase
  end

  // output valid: set on a load, cleared when the result is taken
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (fin || (st_r == ST_IDLE && q_pop && st_nxt == ST_IDLE)) ov_nxt = 1'b1;
  end

  always_comb begin
    mres = pp_ll_r + {pp_lh_r[31:0] + pp_hl_r[31:0], 32'd0};
    if (!cur_r.is_long) mres = sext32(mres[31:0]);
    qv = cur_r.neg_q ? (64'd0 - q_r) : q_r;
    rv = cur_r.neg_r ? (64'd0 - rem_r) : rem_r;
    dres = cur_r.is_rem ? rv : qv;
    if (!cur_r.is_long) dres = sext32(dres[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop) begin
      cur_r <= q_data;
      pp_ll_r <= q_data.a[31:0] * q_data.b[31:0];
      pp_lh_r <= {32'd0, q_data.a[31:0] * q_data.b[63:32]};
      pp_hl_r <= {32'd0, q_data.a[63:32] * q_data.b[31:0]};
      q_r <= mag_a;
      rem_r <= '0;
      dv_r <= mag_b;
      cnt_r <= '0;
      if (st_nxt == ST_IDLE) begin
        dbz_r <= (q_data.cls == CLS_DIV) && q_data.div_zero;
        if (q_data.cls == CLS_DIV)
          res_r <= (q_data.div_zero || q_data.is_rem) ? 64'd0
                 : (q_data.is_long ? 64'h8000_0000_0000_0000 : sext32(32'h8000_0000));
        else
          res_r <= q_data.simple_res;
      end
    end else if (st_r == ST_DIV) begin
      cnt_r <= cnt_r + 1'b1;
      q_r <= {q_r[62:0], !trial[64]};
      rem_r <= trial[64] ? rsh : trial[63:0];
    end else if (fin) begin
      dbz_r <= 1'b0;
      res_r <= (cur_r.cls == CLS_MUL) ? mres : dres;
    end
  end
endmodule

@@ hw/rtl/stack_machine_integer_alu.sv @@
// top level of the integer alu: front end, queue and back end
//  channel | dir | handshake        | payload
//  in_     | in  | valid/ready      | op, first_value, second_value
//  out_    | out | valid/ready      | result, divide_by_zero
// simple ops (add, logic, shift, compare) retire one per cycle while the back end is idle and out is not stalled
// mul registers 32x32 partial products, then sums them into the output register
// div/rem computes one quotient bit a cycle in the shared divider
// reset is synchronous active low and clears queue, back-end state and output valid only
// the queue lets the front accept while the back end or output stalls
module stack_machine_integer_alu (
  input logic clk,
  input logic rst_n,
  smalu_in_if.sink    in_ch,
  smalu_out_if.source out_ch
);
  import smalu_pkg::*;

  dec_t push_data, pop_data;
  logic push, full, pop, not_empty;
  logic [63:0] res;

  // classify and compute the quick results
  smalu_front u_front (
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.op), .in_a(in_ch.first_value), .in_b(in_ch.second_value),
    .q_push(push), .q_data(push_data), .q_full(full)
  );

  // decoupling queue
  smalu_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .not_empty(not_empty)
  );

  // execution and output register
  smalu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(not_empty), .q_data(pop_data), .q_pop(pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result(res), .out_dbz(out_ch.divide_by_zero)
  );

  assign out_ch.result = res;
endmodule

@@ hw/rtl/smalu_checker.sv @@
// port-level checker for the integer alu, bound to the top level
`include "stack_machine_integer_alu_macros.svh"
module smalu_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic        out_dbz
);
  `SMA_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid)
  `SMA_ASSERT_NXT(a_hold_data, out_valid && !out_ready, $stable(out_result))
  `SMA_ASSERT_IMP(a_dbz_zero, out_valid && out_dbz, out_result == 64'd0)
endmodule

bind stack_machine_integer_alu smalu_sva u_sva (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result), .out_dbz(out_ch.divide_by_zero)
);
